// File: src/path_projected_distance_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef PATH_PROJECTED_DISTANCE_MACROS_SVH
`define PATH_PROJECTED_DISTANCE_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define PPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a clock edge.
`define PPD_NEVER(lbl, cond, msg) \
  `PPD_ASSERT(lbl, !(cond), msg)

`endif

// File: src/ppd_pkg.sv
`timescale 1ns / 1ps
package ppd_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 31;

  // Differences of two coordinates, their products and the dot product.
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  // Root width and quotient width, both even for two bits per cycle.
  localparam int RW = 2 * ((COORD_BITS + 3) / 2);
  localparam int LW = 2 * RW;
  localparam int QW = 2 * ((COORD_BITS + 4) / 2);
  localparam int SW = ((QW > DIST_BITS) ? QW : DIST_BITS) + 1;

  localparam int RSTEPS = RW / 2;
  localparam int QSTEPS = QW / 2;
  localparam int CNTW   = $clog2(((RSTEPS > QSTEPS) ? RSTEPS : QSTEPS) + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTRW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNTW  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_EMPTY,
    OP_HEAD,
    OP_SEG
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_ROOT,
    BK_DIV,
    BK_ACC
  } bk_state_e;

  typedef struct packed {
    op_e                          op;
    logic                         last;
    logic signed [COORD_BITS-1:0] nx;
    logic signed [COORD_BITS-1:0] ny;
    logic signed [COORD_BITS-1:0] nz;
    logic signed [DW-1:0]         px;
    logic signed [DW-1:0]         py;
    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// File: src/ppd_front.sv
`timescale 1ns / 1ps
module ppd_front import ppd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] node_x_i,
  input  logic signed [COORD_BITS-1:0] node_y_i,
  input  logic signed [COORD_BITS-1:0] node_z_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic                         first_node_i,
  input  logic                         last_node_i,
  input  logic                         empty_path_i,
  input  fifo_status_t                 fifo_status_i,
  output logic                         push_o,
  output job_t                         job_o
);

  logic signed [COORD_BITS-1:0] prev_x_q, prev_x_d;
  logic signed [COORD_BITS-1:0] prev_y_q, prev_y_d;

  assign in_ready_o = !fifo_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  // Differences are taken one bit wider so that they never wrap.
  always_comb begin
    if (empty_path_i) begin
      job_o.op = OP_EMPTY;
    end else if (first_node_i) begin
      job_o.op = OP_HEAD;
    end else begin
      job_o.op = OP_SEG;
    end
    job_o.last = last_node_i;
    job_o.nx   = node_x_i;
    job_o.ny   = node_y_i;
    job_o.nz   = node_z_i;
    job_o.px   = {node_x_i[COORD_BITS-1], node_x_i} - {query_x_i[COORD_BITS-1], query_x_i};
    job_o.py   = {node_y_i[COORD_BITS-1], node_y_i} - {query_y_i[COORD_BITS-1], query_y_i};
    job_o.dx   = {node_x_i[COORD_BITS-1], node_x_i} - {prev_x_q[COORD_BITS-1], prev_x_q};
    job_o.dy   = {node_y_i[COORD_BITS-1], node_y_i} - {prev_y_q[COORD_BITS-1], prev_y_q};
  end

  always_comb begin
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    if (push_o) begin
      if (empty_path_i) begin
        prev_x_d = '0;
        prev_y_d = '0;
      end else begin
        prev_x_d = node_x_i;
        prev_y_d = node_y_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
    end
  end

endmodule

// File: src/ppd_fifo.sv
`timescale 1ns / 1ps
module ppd_fifo import ppd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  job_t         push_data_i,
  input  logic         pop_i,
  output job_t         pop_data_o,
  output fifo_status_t status_o
);

  job_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTRW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTRW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNTW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == FIFO_CNTW'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTRW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTRW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/ppd_back.sv
`timescale 1ns / 1ps
module ppd_back import ppd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fifo_status_t                 fifo_status_i,
  input  job_t                         fifo_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DIST_BITS-1:0]         distance_o,
  output logic signed [COORD_BITS-1:0] goal_x_o,
  output logic signed [COORD_BITS-1:0] goal_y_o,
  output logic signed [COORD_BITS-1:0] goal_z_o,
  output logic                         saturated_o
);

  localparam logic [DIST_BITS-1:0] DistMax = '1;

  bk_state_e state_q, state_d;

  job_t            job_q;
  logic [CNTW-1:0] cnt_q;
  logic [PW-1:0]   tx_q, ty_q, xx_q, yy_q;
  logic            sx_q, sy_q;
  logic [NW-1:0]   nm_q;
  logic            nonneg_q;
  logic [LW-1:0]   rad_q;
  logic [RW-1:0]   root_q;
  logic [RW+1:0]   srem_q;
  logic [RW-1:0]   drem_q;
  logic [QW-1:0]   dq_q;

  // Running path state.
  logic [DIST_BITS-1:0]         sum_q, sum_d;
  logic                         clip_q, clip_d;
  logic                         open_q, open_d;
  logic signed [COORD_BITS-1:0] gx_q, gx_d, gy_q, gy_d, gz_q, gz_d;

  // Output register.
  logic                         out_valid_q;
  logic [DIST_BITS-1:0]         dist_out_q;
  logic signed [COORD_BITS-1:0] gx_out_q, gy_out_q, gz_out_q;
  logic                         sat_out_q;

  logic [DW-1:0] mpx, mpy, mdx, mdy;
  logic [NW-1:0] nm_c, lsq_c;
  logic          neg_c, nonneg_c;
  logic [LW-1:0] r_rad;
  logic [RW-1:0] r_root;
  logic [RW+1:0] r_rem;
  logic [RW+3:0] t_rem, trial;
  logic [RW-1:0] d_rem;
  logic [QW-1:0] d_q;
  logic [RW:0]   r2;
  logic [SW-1:0] sum_ext;
  logic          need_out, acc_fire, cnt_last_root, cnt_last_div, skip_div;

  function automatic logic [DW-1:0] mag_f(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  assign mpx = mag_f(job_q.px);
  assign mpy = mag_f(job_q.py);
  assign mdx = mag_f(job_q.dx);
  assign mdy = mag_f(job_q.dy);

  // Signed dot product from magnitudes and signs.
  always_comb begin
    if (sx_q == sy_q) begin
      nm_c  = NW'(tx_q) + NW'(ty_q);
      neg_c = sx_q;
    end else if (tx_q >= ty_q) begin
      nm_c  = NW'(tx_q) - NW'(ty_q);
      neg_c = sx_q;
    end else begin
      nm_c  = NW'(ty_q) - NW'(tx_q);
      neg_c = sy_q;
    end
    nonneg_c = !neg_c || (nm_c == '0);
    lsq_c    = NW'(xx_q) + NW'(yy_q);
  end

  // Two digits of the square root per cycle.
  always_comb begin
    r_rem  = srem_q;
    r_root = root_q;
    r_rad  = rad_q;
    t_rem  = '0;
    trial  = '0;
    for (int i = 0; i < 2; i++) begin
      t_rem = {r_rem, r_rad[LW-1 -: 2]};
      trial = {2'b00, r_root, 2'b01};
      if (t_rem >= trial) begin
        t_rem  = t_rem - trial;
        r_root = {r_root[RW-2:0], 1'b1};
      end else begin
        r_root = {r_root[RW-2:0], 1'b0};
      end
      r_rem = t_rem[RW+1:0];
      r_rad = {r_rad[LW-3:0], 2'b00};
    end
  end

  // Two quotient bits per cycle; the remainder always stays below the root.
  always_comb begin
    d_rem = drem_q;
    d_q   = dq_q;
    r2    = '0;
    for (int i = 0; i < 2; i++) begin
      r2 = {d_rem, d_q[QW-1]};
      if (r2 >= {1'b0, root_q}) begin
        r2  = r2 - {1'b0, root_q};
        d_q = {d_q[QW-2:0], 1'b1};
      end else begin
        d_q = {d_q[QW-2:0], 1'b0};
      end
      d_rem = r2[RW-1:0];
    end
  end

  assign cnt_last_root = (cnt_q == CNTW'(RSTEPS - 1));
  assign cnt_last_div  = (cnt_q == CNTW'(QSTEPS - 1));
  assign skip_div      = (r_root == '0) || !nonneg_q;

  // Apply one item to the path state.
  always_comb begin
    sum_d   = sum_q;
    clip_d  = clip_q;
    open_d  = open_q;
    gx_d    = gx_q;
    gy_d    = gy_q;
    gz_d    = gz_q;
    sum_ext = SW'(sum_q) + SW'(dq_q);
    case (job_q.op)
      OP_EMPTY: begin
        sum_d  = '0;
        clip_d = 1'b0;
        open_d = 1'b1;
        gx_d   = '0;
        gy_d   = '0;
        gz_d   = '0;
      end
      OP_HEAD: begin
        sum_d  = '0;
        clip_d = 1'b0;
        open_d = 1'b1;
        gx_d   = job_q.nx;
        gy_d   = job_q.ny;
        gz_d   = job_q.nz;
      end
      OP_SEG: begin
        if (open_q) begin
          gx_d = job_q.nx;
          gy_d = job_q.ny;
          gz_d = job_q.nz;
        end
        if (nonneg_q) begin
          open_d = 1'b0;
          if (sum_ext > SW'(DistMax)) begin
            sum_d  = DistMax;
            clip_d = 1'b1;
          end else begin
            sum_d = sum_ext[DIST_BITS-1:0];
          end
        end
      end
      default: begin
        sum_d = sum_q;
      end
    endcase
  end

  assign need_out = job_q.last || (job_q.op == OP_EMPTY);
  assign acc_fire = (state_q == BK_ACC) && (!need_out || !out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_status_i.empty) begin
          pop_o   = 1'b1;
          state_d = (fifo_data_i.op == OP_SEG) ? BK_MUL : BK_ACC;
        end
      end
      BK_MUL: state_d = BK_SUM;
      BK_SUM: state_d = BK_ROOT;
      BK_ROOT: begin
        if (cnt_last_root) begin
          state_d = skip_div ? BK_ACC : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_last_div) begin
          state_d = BK_ACC;
        end
      end
      BK_ACC: begin
        if (acc_fire) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          job_q <= fifo_data_i;
        end
      end
      BK_MUL: begin
        tx_q <= mpx * mdx;
        ty_q <= mpy * mdy;
        xx_q <= mdx * mdx;
        yy_q <= mdy * mdy;
        sx_q <= job_q.px[DW-1] ^ job_q.dx[DW-1];
        sy_q <= job_q.py[DW-1] ^ job_q.dy[DW-1];
      end
      BK_SUM: begin
        nm_q     <= nm_c;
        nonneg_q <= nonneg_c;
        rad_q    <= LW'(lsq_c);
        root_q   <= '0;
        srem_q   <= '0;
        cnt_q    <= '0;
      end
      BK_ROOT: begin
        rad_q  <= r_rad;
        root_q <= r_root;
        srem_q <= r_rem;
        if (cnt_last_root) begin
          cnt_q  <= '0;
          drem_q <= RW'(nm_q[NW-1:QW]);
          dq_q   <= skip_div ? '0 : nm_q[QW-1:0];
          if (r_root == '0) begin
            nonneg_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      BK_DIV: begin
        drem_q <= d_rem;
        dq_q   <= d_q;
        cnt_q  <= cnt_q + 1'b1;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      clip_q      <= 1'b0;
      open_q      <= 1'b1;
      gx_q        <= '0;
      gy_q        <= '0;
      gz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_fire) begin
        sum_q  <= sum_d;
        clip_q <= clip_d;
        open_q <= open_d;
        gx_q   <= gx_d;
        gy_q   <= gy_d;
        gz_q   <= gz_d;
      end
      if (acc_fire && need_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && need_out) begin
      dist_out_q <= sum_d;
      gx_out_q   <= gx_d;
      gy_out_q   <= gy_d;
      gz_out_q   <= gz_d;
      sat_out_q  <= clip_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_out_q;
  assign goal_x_o    = gx_out_q;
  assign goal_y_o    = gy_out_q;
  assign goal_z_o    = gz_out_q;
  assign saturated_o = sat_out_q;

endmodule

// File: src/path_projected_distance.sv
// Sequence: a segment node goes from acceptance through pop, multiply, add, the root steps,
// the divide steps and the update; a backward or zero-length segment skips the divide,
// and head and empty-path items go straight from pop to update.
// Order: the back end finishes one item before it pops the next;
// a two-entry queue lets the input side run ahead by two items.
// Reset (rst_ni low, asynchronous): queue empty, no result pending, path state cleared.
`timescale 1ns / 1ps
module path_projected_distance import ppd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] node_x_i,
  input  logic signed [COORD_BITS-1:0] node_y_i,
  input  logic signed [COORD_BITS-1:0] node_z_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic                         first_node_i,
  input  logic                         last_node_i,
  input  logic                         empty_path_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DIST_BITS-1:0]         distance_o,
  output logic signed [COORD_BITS-1:0] goal_x_o,
  output logic signed [COORD_BITS-1:0] goal_y_o,
  output logic signed [COORD_BITS-1:0] goal_z_o,
  output logic                         saturated_o
);

  // The front end tracks the previous node itself, so every queued item
  // already carries its query offset and segment direction. The back end
  // owns the running sum, the goal and the result register.
  fifo_status_t fifo_status;
  logic         push;
  logic         pop;
  job_t         push_job;
  job_t         head_job;

  ppd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .node_x_i      (node_x_i),
    .node_y_i      (node_y_i),
    .node_z_i      (node_z_i),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .first_node_i  (first_node_i),
    .last_node_i   (last_node_i),
    .empty_path_i  (empty_path_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .job_o         (push_job)
  );

  // The queue decouples acceptance from the long per-segment computation.
  ppd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (head_job),
    .status_o    (fifo_status)
  );

  // The back end works on one item at a time: it forms the dot product and
  // the squared length, takes the square root and divides two bits per cycle,
  // then folds the projection into the path state. A result waits in its own
  // register, so the queue keeps filling while the consumer stalls.
  ppd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .fifo_data_i   (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_o    (distance_o),
    .goal_x_o      (goal_x_o),
    .goal_y_o      (goal_y_o),
    .goal_z_o      (goal_z_o),
    .saturated_o   (saturated_o)
  );

endmodule

// File: src/ppd_checker.sv
`timescale 1ns / 1ps
`include "path_projected_distance_macros.svh"
module ppd_checker import ppd_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic signed [COORD_BITS-1:0] node_x_i,
  input logic signed [COORD_BITS-1:0] node_y_i,
  input logic signed [COORD_BITS-1:0] node_z_i,
  input logic signed [COORD_BITS-1:0] query_x_i,
  input logic signed [COORD_BITS-1:0] query_y_i,
  input logic                         first_node_i,
  input logic                         last_node_i,
  input logic                         empty_path_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [DIST_BITS-1:0]         distance_o,
  input logic signed [COORD_BITS-1:0] goal_x_o,
  input logic signed [COORD_BITS-1:0] goal_y_o,
  input logic signed [COORD_BITS-1:0] goal_z_o,
  input logic                         saturated_o
);

  // A stalled result keeps its value.
  `PPD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(goal_x_o) && $stable(goal_y_o) && $stable(goal_z_o) && $stable(saturated_o), "stalled result changed")

  // A result leaves only when it is taken.
  `PPD_ASSERT(a_out_drop, $fell(out_valid_o) |-> $past(out_ready_i), "result dropped without acceptance")

  // A clipped sum always reads as the largest distance.
  `PPD_NEVER(a_sat_max, out_valid_o && saturated_o && (distance_o != '1), "clipped sum below maximum")

  // The queue fills only when an item is taken in.
  `PPD_ASSERT(a_ready_fall, $fell(in_ready_o) |-> $past(in_valid_i), "ready fell without an item")

endmodule

bind path_projected_distance ppd_checker u_checker (.*);
